>>> rtl/plwc_pkg.sv
package plwc_pkg;

	localparam int COORD_BITS = 24;
	localparam int SUM_BITS   = 61;
	localparam int LEN_BITS   = 35;

	// segment arithmetic
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MUL_BITS   = DIFF_BITS + 1;
	localparam int PROD_BITS  = 2 * MUL_BITS;
	localparam int SQ_BITS    = 2 * DIFF_BITS;
	localparam int ROOT_BITS  = DIFF_BITS;
	localparam int REM_BITS   = ROOT_BITS + 2;
	localparam int SQRT_STEPS = ROOT_BITS;

	// final division
	localparam int DIV_BITS   = SUM_BITS + 1;
	localparam int DVS_BITS   = LEN_BITS + 1;
	localparam int CNT_BITS   = $clog2(DIV_BITS);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SUM,
		S_SQRT,
		S_ROUND,
		S_PX,
		S_PY,
		S_ACC,
		S_FINISH,
		S_DIV,
		S_OUT
	} state_t;

endpackage

>>> rtl/plwc_vertex_if.sv
interface plwc_vertex_if import plwc_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t vertex_x;
	coord_t vertex_y;
	logic   last_vertex;

	modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

>>> rtl/plwc_centroid_if.sv
interface plwc_centroid_if import plwc_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t centroid_x;
	coord_t centroid_y;
	logic   zero_length;

	modport source (output valid, output centroid_x, output centroid_y, output zero_length,
		input ready);
	modport sink (input valid, input centroid_x, input centroid_y, input zero_length,
		output ready);
endinterface

>>> rtl/polyline_length_weighted_centroid.sv
// Length weighted polyline centroid with one shared multiplier. A vertex is taken only
// in the idle state, so the next one waits until the previous segment is accumulated;
// the 25-step bit-serial square root of a segment's squared length is the longest part.
// A last vertex then starts two 62-step divisions (x, then y; none at zero length);
// the input stalls while a finished result waits behind an unaccepted one.
// Reset (arst_n low, asynchronous) clears the sequencer, accumulators and output valid.
module polyline_length_weighted_centroid import plwc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	plwc_vertex_if.sink    vertex,
	plwc_centroid_if.source centroid
);

	state_t state_q, state_d;

	coord_t cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic   last_q, have_prev_q;

	logic signed [PROD_BITS-1:0] prod_q;
	logic [SQ_BITS-1:0]          sq_q;
	logic [REM_BITS-1:0]         rem_q;
	logic [ROOT_BITS-1:0]        root_q;
	logic [ROOT_BITS-1:0]        len_q;
	logic [SUM_BITS-1:0]         wsx_q, wsy_q;
	logic [LEN_BITS-1:0]         total_q;
	logic [CNT_BITS-1:0]         cnt_q;

	logic [DVS_BITS-1:0]         div_rem_q;
	logic [DIV_BITS-1:0]         dq_q;
	logic                        div_y_q, neg_q;
	coord_t                      cx_q, cy_q;
	logic                        zero_q;

	coord_t out_x_q, out_y_q;
	logic   out_zero_q, out_valid_q;

	logic in_acc, out_load;

	// shared multiplier
	logic signed [DIFF_BITS-1:0] dx, dy, sx, sy;
	logic signed [MUL_BITS-1:0]  mul_a, mul_b;
	logic signed [PROD_BITS-1:0] prod;
	logic [SUM_BITS-1:0]         prod_ext;

	// square root step
	logic [REM_BITS+1:0] rem_sh, trial;
	logic                sq_ge;

	// division step
	logic [DVS_BITS:0]   div_sh, div_dvs;
	logic                div_ge;
	logic [DIV_BITS-1:0] q_next;
	coord_t              q_sat;
	logic [SUM_BITS-1:0] setup_sum, setup_mag;
	logic                setup_neg;

	assign in_acc = vertex.valid && vertex.ready;

	assign dx = DIFF_BITS'(cur_x_q) - DIFF_BITS'(prev_x_q);
	assign dy = DIFF_BITS'(cur_y_q) - DIFF_BITS'(prev_y_q);
	assign sx = DIFF_BITS'(cur_x_q) + DIFF_BITS'(prev_x_q);
	assign sy = DIFF_BITS'(cur_y_q) + DIFF_BITS'(prev_y_q);

	always_comb begin
		mul_a = MUL_BITS'(dx);
		mul_b = MUL_BITS'(dx);
		case (state_q)
			S_SQY: begin
				mul_a = MUL_BITS'(dy);
				mul_b = MUL_BITS'(dy);
			end
			S_PX: begin
				mul_a = signed'({1'b0, len_q});
				mul_b = MUL_BITS'(sx);
			end
			S_PY: begin
				mul_a = signed'({1'b0, len_q});
				mul_b = MUL_BITS'(sy);
			end
			default: begin
				mul_a = MUL_BITS'(dx);
				mul_b = MUL_BITS'(dx);
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = SUM_BITS'(prod_q);

	assign rem_sh = {rem_q, sq_q[SQ_BITS-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign sq_ge  = rem_sh >= trial;

	assign div_sh  = {div_rem_q, dq_q[DIV_BITS-1]};
	assign div_dvs = {1'b0, total_q, 1'b0};
	assign div_ge  = div_sh >= div_dvs;
	assign q_next  = {dq_q[DIV_BITS-2:0], div_ge};

	// saturate quotient to the signed coordinate range
	always_comb begin
		if (neg_q) begin
			if (q_next > DIV_BITS'(1 << (COORD_BITS-1)))
				q_sat = {1'b1, {(COORD_BITS-1){1'b0}}};
			else
				q_sat = COORD_BITS'(-q_next);
		end else begin
			if (q_next > DIV_BITS'((1 << (COORD_BITS-1)) - 1))
				q_sat = {1'b0, {(COORD_BITS-1){1'b1}}};
			else
				q_sat = q_next[COORD_BITS-1:0];
		end
	end

	assign setup_sum = (state_q == S_FINISH) ? wsx_q : wsy_q;
	assign setup_neg = setup_sum[SUM_BITS-1];
	assign setup_mag = setup_neg ? (~setup_sum + 1'b1) : setup_sum;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		vertex.ready = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				vertex.ready = 1'b1;
				if (vertex.valid) begin
					if (have_prev_q)
						state_d = S_SQX;
					else if (vertex.last_vertex)
						state_d = S_FINISH;
				end
			end
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_SUM;
			S_SUM:   state_d = S_SQRT;
			S_SQRT: begin
				if (cnt_q == CNT_BITS'(SQRT_STEPS-1))
					state_d = S_ROUND;
			end
			S_ROUND: state_d = S_PX;
			S_PX:    state_d = S_PY;
			S_PY:    state_d = S_ACC;
			S_ACC:   state_d = last_q ? S_FINISH : S_IDLE;
			S_FINISH: state_d = (total_q == '0) ? S_OUT : S_DIV;
			S_DIV: begin
				if (cnt_q == CNT_BITS'(DIV_BITS-1) && div_y_q)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || centroid.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			wsx_q       <= '0;
			wsy_q       <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (centroid.valid && centroid.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						have_prev_q <= 1'b1;
				end
				S_SUM:  cnt_q <= '0;
				S_SQRT: cnt_q <= cnt_q + 1'b1;
				S_PY: begin
					wsx_q   <= wsx_q + prod_ext;
					total_q <= total_q + LEN_BITS'(len_q);
				end
				S_ACC:    wsy_q <= wsy_q + prod_ext;
				S_FINISH: cnt_q <= '0;
				S_DIV: begin
					if (cnt_q == CNT_BITS'(DIV_BITS-1))
						cnt_q <= '0;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_OUT: begin
					if (out_load) begin
						have_prev_q <= 1'b0;
						wsx_q       <= '0;
						wsy_q       <= '0;
						total_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cur_x_q <= vertex.vertex_x;
					cur_y_q <= vertex.vertex_y;
					last_q  <= vertex.last_vertex;
					if (!have_prev_q) begin
						prev_x_q <= vertex.vertex_x;
						prev_y_q <= vertex.vertex_y;
					end
				end
			end
			S_SQX: prod_q <= prod;
			S_SQY: begin
				sq_q   <= prod_q[SQ_BITS-1:0];
				prod_q <= prod;
			end
			S_SUM: begin
				sq_q   <= sq_q + prod_q[SQ_BITS-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				rem_q  <= sq_ge ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
				root_q <= {root_q[ROOT_BITS-2:0], sq_ge};
				sq_q   <= {sq_q[SQ_BITS-3:0], 2'b00};
			end
			S_ROUND: len_q <= root_q + ROOT_BITS'(rem_q > REM_BITS'(root_q));
			S_PX:    prod_q <= prod;
			S_PY:    prod_q <= prod;
			S_ACC: begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
			end
			S_FINISH: begin
				cx_q      <= '0;
				cy_q      <= '0;
				zero_q    <= (total_q == '0);
				div_y_q   <= 1'b0;
				neg_q     <= setup_neg;
				dq_q      <= DIV_BITS'(setup_mag) + DIV_BITS'(total_q);
				div_rem_q <= '0;
			end
			S_DIV: begin
				if (cnt_q == CNT_BITS'(DIV_BITS-1) && !div_y_q) begin
					// x done: start y
					cx_q      <= q_sat;
					div_y_q   <= 1'b1;
					neg_q     <= setup_neg;
					dq_q      <= DIV_BITS'(setup_mag) + DIV_BITS'(total_q);
					div_rem_q <= '0;
				end else begin
					div_rem_q <= div_ge ? DVS_BITS'(div_sh - div_dvs) : DVS_BITS'(div_sh);
					dq_q      <= q_next;
					if (cnt_q == CNT_BITS'(DIV_BITS-1))
						cy_q <= q_sat;
				end
			end
			S_OUT: begin
				if (out_load) begin
					out_x_q    <= cx_q;
					out_y_q    <= cy_q;
					out_zero_q <= zero_q;
				end
			end
			default: ;
		endcase
	end

	assign centroid.valid       = out_valid_q;
	assign centroid.centroid_x  = out_x_q;
	assign centroid.centroid_y  = out_y_q;
	assign centroid.zero_length = out_zero_q;

endmodule

>>> rtl/plwc_checker.sv
module plwc_checker import plwc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   in_last,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t out_x,
	input coord_t out_y,
	input logic   out_zero
);

	// a last vertex always keeps the block busy for the following cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("ready high right after a last vertex");

	// a zero length polyline reports the origin
	a_zero_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zero |-> out_x == '0 && out_y == '0)
		else $error("zero length result with nonzero centroid");

	// a new result never appears while the block still accepts vertices mid-polyline
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a busy cycle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_zero))
		else $error("stalled result changed");

endmodule

bind polyline_length_weighted_centroid plwc_checker u_plwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex.valid),
	.in_ready  (vertex.ready),
	.in_last   (vertex.last_vertex),
	.out_valid (centroid.valid),
	.out_ready (centroid.ready),
	.out_x     (centroid.centroid_x),
	.out_y     (centroid.centroid_y),
	.out_zero  (centroid.zero_length)
);
